/* rtl/assert_macros.svh */
// Assertion macros for the segment intersection block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every cycle outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/segi_pkg.sv */
// ---------------------------------------------------------------------------
// segi_pkg
// Shared constants for the segment intersection test.
// ---------------------------------------------------------------------------
package segi_pkg;
    // register stages ahead of the divider
    localparam int unsigned DivLatencyExtra = 6;
endpackage

/* rtl/segment_intersection_test.sv */
// ---------------------------------------------------------------------------
// segment_intersection_test
// Pipelined strict segment crossing test with crossing point output.
// ---------------------------------------------------------------------------
// Usage:
//   Drive the eight endpoint coordinates and raise start. busy is always
//   low, so an item is taken on every cycle where start is high.
//   Each item gives one result marked by o_valid, in item order. Throughput
//   is one item per cycle. With W = COORD_WIDTH, the pipeline is the
//   restoring divider, unrolled into one quotient bit per pipeline stage
//   (W+1 stages), plus six stages ahead of it and one output stage.
//   Stages: differences, products, cross products, sign/magnitude tests,
//   R*t numerator halves, their sum, then the divider, then the final add.
//   The receiver cannot stall; results are shown for one cycle only.
//   Reset clears all valid bits; items in flight are dropped.
//   Outputs other than o_valid hold don't-care values while o_valid is low.
// ---------------------------------------------------------------------------
module segment_intersection_test #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_a_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_a_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_end_y,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic                          o_collinear,
    output logic                          o_point_valid,
    output logic signed [COORD_WIDTH-1:0] o_cross_x,
    output logic signed [COORD_WIDTH-1:0] o_cross_y
);
    import segi_pkg::*;

    // differences: W+1 bits, products 2W+2, cross 2W+3
    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int CW = PW + 1;
    // numerator |R|*|qps| < 2^DW * 2^CW
    localparam int NW = DW + CW;
    // quotient |R*t| < 2^DW
    localparam int QW = DW;
    localparam int NSTG = QW;

    localparam int FracUnused = FRAC_BITS;

    assign busy = 1'b0;

    // ---------------- stage 1: differences
    logic                 r1_v;
    logic signed [DW-1:0] r1_px, r1_py, r1_rx, r1_ry, r1_sx, r1_sy, r1_dx, r1_dy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start & ~busy;
        end
        r1_px <= DW'(i_a_start_x);
        r1_py <= DW'(i_a_start_y);
        r1_rx <= DW'(i_a_end_x) - DW'(i_a_start_x);
        r1_ry <= DW'(i_a_end_y) - DW'(i_a_start_y);
        r1_sx <= DW'(i_b_end_x) - DW'(i_b_start_x);
        r1_sy <= DW'(i_b_end_y) - DW'(i_b_start_y);
        r1_dx <= DW'(i_b_start_x) - DW'(i_a_start_x);
        r1_dy <= DW'(i_b_start_y) - DW'(i_a_start_y);
    end

    // ---------------- stage 2: six products
    logic                 r2_v;
    logic signed [PW-1:0] r2_rxsy, r2_rysx, r2_dxsy, r2_dysx, r2_dxry, r2_dyrx;
    logic signed [DW-1:0] r2_px, r2_py, r2_rx, r2_ry;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_rxsy <= PW'(r1_rx) * PW'(r1_sy);
        r2_rysx <= PW'(r1_ry) * PW'(r1_sx);
        r2_dxsy <= PW'(r1_dx) * PW'(r1_sy);
        r2_dysx <= PW'(r1_dy) * PW'(r1_sx);
        r2_dxry <= PW'(r1_dx) * PW'(r1_ry);
        r2_dyrx <= PW'(r1_dy) * PW'(r1_rx);
        r2_px <= r1_px;
        r2_py <= r1_py;
        r2_rx <= r1_rx;
        r2_ry <= r1_ry;
    end

    // ---------------- stage 3: cross products
    logic                 r3_v;
    logic signed [CW-1:0] r3_rs, r3_qps, r3_qpr;
    logic signed [DW-1:0] r3_px, r3_py, r3_rx, r3_ry;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_rs  <= CW'(r2_rxsy) - CW'(r2_rysx);
        r3_qps <= CW'(r2_dxsy) - CW'(r2_dysx);
        r3_qpr <= CW'(r2_dxry) - CW'(r2_dyrx);
        r3_px <= r2_px;
        r3_py <= r2_py;
        r3_rx <= r2_rx;
        r3_ry <= r2_ry;
    end

    // ---------------- stage 4: decisions and magnitudes
    logic               r4_v, r4_hit, r4_col, r4_pv, r4_negx, r4_negy;
    logic [CW-1:0]      r4_aqps, r4_ars;
    logic [DW-1:0]      r4_arx, r4_ary;
    logic signed [DW-1:0] r4_px, r4_py;
    logic [CW-1:0]      s4_aqps, s4_aqpr, s4_ars;
    logic               s4_rs0, s4_t_ok, s4_u_ok;
    always_comb begin
        s4_aqps = r3_qps[CW-1] ? CW'(-r3_qps) : CW'(r3_qps);
        s4_aqpr = r3_qpr[CW-1] ? CW'(-r3_qpr) : CW'(r3_qpr);
        s4_ars  = r3_rs[CW-1]  ? CW'(-r3_rs)  : CW'(r3_rs);
        s4_rs0  = (r3_rs == '0);
        s4_t_ok = (r3_qps != '0) && (r3_qps[CW-1] == r3_rs[CW-1]) && (s4_aqps < s4_ars);
        s4_u_ok = (r3_qpr != '0) && (r3_qpr[CW-1] == r3_rs[CW-1]) && (s4_aqpr < s4_ars);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
        r4_col  <= s4_rs0 && (r3_qpr == '0);
        r4_pv   <= !s4_rs0 && s4_t_ok && s4_u_ok;
        r4_hit  <= s4_rs0 ? (r3_qpr == '0) : (s4_t_ok && s4_u_ok);
        // t positive on a hit, so sign of R*t follows R
        r4_negx <= r3_rx[DW-1];
        r4_negy <= r3_ry[DW-1];
        r4_arx  <= r3_rx[DW-1] ? DW'(-r3_rx) : DW'(r3_rx);
        r4_ary  <= r3_ry[DW-1] ? DW'(-r3_ry) : DW'(r3_ry);
        r4_aqps <= s4_aqps;
        r4_ars  <= s4_ars;
        r4_px   <= r3_px;
        r4_py   <= r3_py;
    end

    // ---------------- stage 5: numerators |R|*|qps| (split in halves)
    localparam int HW = (CW + 1) / 2;
    logic               r5_v, r5_hit, r5_col, r5_pv, r5_negx, r5_negy;
    logic [DW+HW-1:0]   r5_xl, r5_xh, r5_yl, r5_yh;
    logic [CW-1:0]      r5_ars;
    logic signed [DW-1:0] r5_px, r5_py;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
        r5_xl <= (DW+HW)'(r4_arx) * (DW+HW)'(r4_aqps[HW-1:0]);
        r5_xh <= (DW+HW)'(r4_arx) * (DW+HW)'(r4_aqps[CW-1:HW]);
        r5_yl <= (DW+HW)'(r4_ary) * (DW+HW)'(r4_aqps[HW-1:0]);
        r5_yh <= (DW+HW)'(r4_ary) * (DW+HW)'(r4_aqps[CW-1:HW]);
        r5_hit <= r4_hit; r5_col <= r4_col; r5_pv <= r4_pv;
        r5_negx <= r4_negx; r5_negy <= r4_negy;
        r5_ars <= r4_ars; r5_px <= r4_px; r5_py <= r4_py;
    end

    // ---------------- stage 6: sum the halves
    logic               r6_v, r6_hit, r6_col, r6_pv, r6_negx, r6_negy;
    logic [NW-1:0]      r6_nx, r6_ny;
    logic [CW-1:0]      r6_ars;
    logic signed [DW-1:0] r6_px, r6_py;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
        end
        r6_nx <= NW'(r5_xl) + (NW'(r5_xh) << HW);
        r6_ny <= NW'(r5_yl) + (NW'(r5_yh) << HW);
        r6_hit <= r5_hit; r6_col <= r5_col; r6_pv <= r5_pv;
        r6_negx <= r5_negx; r6_negy <= r5_negy;
        r6_ars <= r5_ars; r6_px <= r5_px; r6_py <= r5_py;
    end

    // ---------------- divider: one quotient bit per stage, MSB first
    // remainder stays below the divisor, so CW+1 bits suffice
    typedef struct packed {
        logic          hit;
        logic          col;
        logic          pv;
        logic          negx;
        logic          negy;
        logic [CW-1:0] den;
        logic [NW-1:0] nx;
        logic [NW-1:0] ny;
        logic [CW:0]   remx;
        logic [CW:0]   remy;
        logic [QW-1:0] qx;
        logic [QW-1:0] qy;
        logic [DW-1:0] px;
        logic [DW-1:0] py;
    } t_div;

    t_div         s_dv0;
    logic         s_dvv0;
    t_div         r_dv  [NSTG];
    logic         r_dvv [NSTG];

    always_comb begin
        s_dv0 = '0;
        s_dv0.hit = r6_hit; s_dv0.col = r6_col; s_dv0.pv = r6_pv;
        s_dv0.negx = r6_negx; s_dv0.negy = r6_negy;
        s_dv0.den = r6_ars; s_dv0.nx = r6_nx; s_dv0.ny = r6_ny;
        s_dv0.remx = (CW+1)'(r6_nx >> QW);
        s_dv0.remy = (CW+1)'(r6_ny >> QW);
        s_dv0.px = r6_px; s_dv0.py = r6_py;
        s_dvv0 = r6_v;
    end

    for (genvar g = 0; g < NSTG; g++) begin : g_div
        t_div          s_cur, s_nxt;
        logic          s_curv;
        logic [CW+1:0] tx, ty;
        if (g == 0) begin : g_head
            assign s_cur  = s_dv0;
            assign s_curv = s_dvv0;
        end else begin : g_body
            assign s_cur  = r_dv[g-1];
            assign s_curv = r_dvv[g-1];
        end
        always_comb begin
            s_nxt = s_cur;
            tx = {s_cur.remx, s_cur.nx[QW-1-g]};
            ty = {s_cur.remy, s_cur.ny[QW-1-g]};
            if (tx >= (CW+2)'(s_cur.den)) begin
                tx = tx - (CW+2)'(s_cur.den);
                s_nxt.qx[QW-1-g] = 1'b1;
            end
            if (ty >= (CW+2)'(s_cur.den)) begin
                ty = ty - (CW+2)'(s_cur.den);
                s_nxt.qy[QW-1-g] = 1'b1;
            end
            s_nxt.remx = tx[CW:0];
            s_nxt.remy = ty[CW:0];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvv[g] <= 1'b0;
            end else begin
                r_dvv[g] <= s_curv;
            end
            r_dv[g] <= s_nxt;
        end
    end

    // ---------------- final stage: signed add
    logic                          r_ov, r_ohit, r_ocol, r_opv;
    logic signed [COORD_WIDTH-1:0] r_ox, r_oy;
    t_div                          s_f;
    logic signed [DW:0]            s_sx, s_sy;
    always_comb begin
        s_f  = r_dv[NSTG-1];
        s_sx = s_f.negx ? -(DW+1)'(s_f.qx) : (DW+1)'(s_f.qx);
        s_sy = s_f.negy ? -(DW+1)'(s_f.qy) : (DW+1)'(s_f.qy);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_dvv[NSTG-1];
        end
        r_ohit <= s_f.hit;
        r_ocol <= s_f.col;
        r_opv  <= s_f.pv;
        r_ox <= s_f.pv ? COORD_WIDTH'((DW+1)'(signed'(s_f.px)) + s_sx) : '0;
        r_oy <= s_f.pv ? COORD_WIDTH'((DW+1)'(signed'(s_f.py)) + s_sy) : '0;
    end

    assign o_valid       = r_ov;
    assign o_hit         = r_ohit;
    assign o_collinear   = r_ocol;
    assign o_point_valid = r_opv;
    assign o_cross_x     = r_ox;
    assign o_cross_y     = r_oy;

    logic unused_ok;
    assign unused_ok = (FracUnused >= 0) && (DivLatencyExtra > 0);

`include "assert_macros.svh"
    `ASSERT_IMPL(a_pv_hit, i_clk, i_rst_n, o_valid && o_point_valid, o_hit && !o_collinear)
    `ASSERT_IMPL(a_col_hit, i_clk, i_rst_n, o_valid && o_collinear, o_hit && !o_point_valid)
    `ASSERT_NEXT(a_flow, i_clk, i_rst_n, r_dvv[NSTG-1] && unused_ok, o_valid)
endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Segment crossing test bench
// Sends segment pairs with random gaps and keeps its own model of the block:
// cross products, a strict crossing test and the truncated crossing point.
// Each result strobe is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = 16;
    localparam int CYCLE_CAP = 600000;
    localparam int TAIL      = 80;

    typedef struct {
        logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        bit                   drain;
    } seg_pair_t;

    typedef struct {
        logic                 hit;
        logic                 collinear;
        logic                 point_valid;
        logic signed [CW-1:0] cross_x;
        logic signed [CW-1:0] cross_y;
    } crossing_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [CW-1:0] i_a_start_x = '0, i_a_start_y = '0, i_a_end_x = '0, i_a_end_y = '0;
    logic signed [CW-1:0] i_b_start_x = '0, i_b_start_y = '0, i_b_end_x = '0, i_b_end_y = '0;
    logic o_valid, o_hit, o_collinear, o_point_valid;
    logic signed [CW-1:0] o_cross_x, o_cross_y;

    seg_pair_t pair_queue[$];
    crossing_t crossing_queue[$];
    int unsigned gap_left = 0;
    int unsigned mismatches = 0;
    int unsigned n_sent = 0, n_checked = 0, n_hits = 0, n_colin = 0, n_points = 0;
    int unsigned cycles = 0;

    segment_intersection_test #(.COORD_WIDTH(CW), .FRAC_BITS(4)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_a_start_x(i_a_start_x), .i_a_start_y(i_a_start_y),
        .i_a_end_x(i_a_end_x), .i_a_end_y(i_a_end_y),
        .i_b_start_x(i_b_start_x), .i_b_start_y(i_b_start_y),
        .i_b_end_x(i_b_end_x), .i_b_end_y(i_b_end_y),
        .o_valid(o_valid), .o_hit(o_hit), .o_collinear(o_collinear),
        .o_point_valid(o_point_valid), .o_cross_x(o_cross_x), .o_cross_y(o_cross_y)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // strict 0 < num/den < 1
    function automatic bit open_unit(longint num, longint den);
        return num != 0 && ((num < 0) == (den < 0)) && mag(num) < mag(den);
    endfunction

    // r * num / den, truncated toward zero
    function automatic longint scale_trunc(longint r, longint num, longint den);
        longint q;
        q = (mag(r) * mag(num)) / mag(den);
        return ((r < 0) ^ (num < 0) ^ (den < 0)) ? -q : q;
    endfunction

    function automatic crossing_t predict_crossing(seg_pair_t s);
        longint px, py, rx, ry, qx, qy, sx, sy, dx, dy, rs, qps, qpr, x, y;
        crossing_t c;
        px = longint'(s.ax0); py = longint'(s.ay0);
        rx = longint'(s.ax1) - px; ry = longint'(s.ay1) - py;
        qx = longint'(s.bx0); qy = longint'(s.by0);
        sx = longint'(s.bx1) - qx; sy = longint'(s.by1) - qy;
        dx = qx - px; dy = qy - py;
        rs  = rx * sy - ry * sx;
        qps = dx * sy - dy * sx;
        qpr = dx * ry - dy * rx;
        c = '{1'b0, 1'b0, 1'b0, '0, '0};
        if (rs == 0) begin
            if (qpr == 0) begin
                c.hit = 1'b1;
                c.collinear = 1'b1;
            end
        end else if (open_unit(qps, rs) && open_unit(qpr, rs)) begin
            x = px + scale_trunc(rx, qps, rs);
            y = py + scale_trunc(ry, qps, rs);
            c.hit = 1'b1;
            c.point_valid = 1'b1;
            c.cross_x = x[CW-1:0];
            c.cross_y = y[CW-1:0];
        end
        return c;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    task automatic add_pair(int ax0, int ay0, int ax1, int ay1,
                            int bx0, int by0, int bx1, int by1, bit drain = 1'b0);
        seg_pair_t s;
        s.ax0 = CW'(ax0); s.ay0 = CW'(ay0); s.ax1 = CW'(ax1); s.ay1 = CW'(ay1);
        s.bx0 = CW'(bx0); s.by0 = CW'(by0); s.bx1 = CW'(bx1); s.by1 = CW'(by1);
        s.drain = drain;
        pair_queue.push_back(s);
    endtask

    function automatic int rnd_full();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int rnd_span(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    task automatic add_random_pair(bit drain);
        int unsigned kind;
        int cx, cy, ux, uy, wx, wy, k;
        kind = $urandom_range(0, 99);
        cx = rnd_span(8000); cy = rnd_span(8000);
        ux = rnd_span(8000); uy = rnd_span(8000);
        wx = rnd_span(8000); wy = rnd_span(8000);
        if (kind < 35) begin
            // crossing through a common point
            k = $urandom_range(0, 2);
            add_pair(cx - ux, cy - uy, cx + (ux >>> k), cy + (uy >>> k),
                     cx - (wx >>> k), cy - (wy >>> k), cx + wx, cy + wy, drain);
        end else if (kind < 45) begin
            // collinear, overlapping or not
            ux = rnd_span(200); uy = rnd_span(200);
            k = rnd_span(30);
            add_pair(cx, cy, cx + ux, cy + uy, cx + k * ux, cy + k * uy,
                     cx + rnd_span(20) * ux, cy + rnd_span(20) * uy, drain);
        end else if (kind < 55) begin
            // parallel offset
            add_pair(cx, cy, cx + ux, cy + uy, cx + wx, cy + wy,
                     cx + wx + ux, cy + wy + uy, drain);
        end else if (kind < 75) begin
            add_pair(rnd_span(40), rnd_span(40), rnd_span(40), rnd_span(40),
                     rnd_span(40), rnd_span(40), rnd_span(40), rnd_span(40), drain);
        end else begin
            add_pair(rnd_full(), rnd_full(), rnd_full(), rnd_full(),
                     rnd_full(), rnd_full(), rnd_full(), rnd_full(), drain);
        end
    endtask

    initial begin
        // directed corners
        add_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        add_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        add_pair(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768);
        add_pair(0, 0, 160, 160, 0, 160, 160, 0);
        add_pair(-100, -50, 300, 70, 20, -400, -10, 500);
        add_pair(0, 0, 100, 0, 0, 10, 100, 10);       // parallel
        add_pair(0, 0, 100, 0, 50, 0, 200, 0);        // collinear overlap
        add_pair(0, 0, 100, 0, 300, 0, 500, 0);       // collinear apart
        add_pair(5, 5, 5, 5, 5, 5, 9, 9);             // zero-length segment
        add_pair(7, 7, 7, 7, 100, -3, 100, -3);       // both zero length
        add_pair(0, 0, 100, 100, 100, 100, 200, 0);   // shared endpoint
        add_pair(0, 0, 100, 0, 50, 0, 50, 100);       // touching, u = 0
        add_pair(0, 0, 100, 0, 100, -50, 100, 50);    // touching, t = 1
        add_pair(0, 0, 10, 10, 100, 0, 0, 100);       // lines cross outside A
        add_pair(0, 0, 3, 0, 1, -1, 2, 1);            // truncated point
        add_pair(0, 0, -3, -7, -1, 1, -2, -9);
        add_pair(32767, 0, -32768, 1, 0, 32767, 1, -32768);
        for (int i = 0; i < 1830; i++)
            add_random_pair(i == 40 || i == 900 || i == 1500);
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // driver
    always @(posedge i_clk) begin
        seg_pair_t s;
        bit take;
        take = start && !busy;
        if (take) begin
            s.ax0 = i_a_start_x; s.ay0 = i_a_start_y; s.ax1 = i_a_end_x; s.ay1 = i_a_end_y;
            s.bx0 = i_b_start_x; s.by0 = i_b_start_y; s.bx1 = i_b_end_x; s.by1 = i_b_end_y;
            crossing_queue.push_back(predict_crossing(s));
            n_sent++;
        end
        if (i_rst_n && start && !take) begin
            start <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
        end else if (i_rst_n && pair_queue.size() > 0 &&
                     !(pair_queue[0].drain && crossing_queue.size() > 0)) begin
            s = pair_queue.pop_front();
            i_a_start_x <= s.ax0; i_a_start_y <= s.ay0;
            i_a_end_x <= s.ax1; i_a_end_y <= s.ay1;
            i_b_start_x <= s.bx0; i_b_start_y <= s.by0;
            i_b_end_x <= s.bx1; i_b_end_y <= s.by1;
            start <= 1'b1;
            gap_left = pick_gap();
        end else begin
            start <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        crossing_t e;
        if (i_rst_n && o_valid) begin
            if (crossing_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no item outstanding: hit=%0b colin=%0b pv=%0b",
                             o_hit, o_collinear, o_point_valid);
            end else begin
                e = crossing_queue.pop_front();
                n_checked++;
                if (e.hit) n_hits++;
                if (e.collinear) n_colin++;
                if (e.point_valid) n_points++;
                if (o_hit !== e.hit || o_collinear !== e.collinear ||
                    o_point_valid !== e.point_valid ||
                    o_cross_x !== e.cross_x || o_cross_y !== e.cross_y) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch #%0d: exp hit=%0b colin=%0b pv=%0b x=%0d y=%0d, got hit=%0b colin=%0b pv=%0b x=%0d y=%0d",
                                 n_checked, e.hit, e.collinear, e.point_valid,
                                 e.cross_x, e.cross_y, o_hit, o_collinear,
                                 o_point_valid, o_cross_x, o_cross_y);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("timeout with %0d results outstanding", crossing_queue.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        wait (i_rst_n);
        wait (pair_queue.size() == 0 && !start);
        wait (crossing_queue.size() == 0);
        repeat (TAIL) @(posedge i_clk);
        if (crossing_queue.size() > 0) mismatches++;
        $display("%0d segment pairs sent, %0d results checked", n_sent, n_checked);
        $display("%0d hits: %0d collinear, %0d with crossing point", n_hits, n_colin, n_points);
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/segi_pkg.sv
rtl/segment_intersection_test.sv
tb/testbench.sv
